// ===== design/tga_rle_pkg.sv =====
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder package
// Shared types and codes for the configuration block, the decode stage and
// the top level.
// ----------------------------------------------------------------------------
package tga_rle_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_PIXEL_MODE   = 2'd0,
        CFG_RLE_ENABLE   = 2'd1,
        CFG_IMAGE_WIDTH  = 2'd2,
        CFG_IMAGE_HEIGHT = 2'd3
    } cfg_index_t;

    // Pixel formats; the fourth code is handled like BGRA.
    typedef enum logic [1:0] {
        MODE_GRAY  = 2'd0,
        MODE_BGR   = 2'd1,
        MODE_BGRA  = 2'd2,
        MODE_OTHER = 2'd3
    } pixel_mode_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_EARLY_END = 2'd1,
        ERR_OVERRUN   = 2'd2
    } err_code_t;

    localparam int unsigned HDR_REPEAT_BIT = 7;
    localparam int unsigned HDR_COUNT_W    = 7;
    localparam int unsigned DIM_W          = 16;
    localparam int unsigned TOTAL_W        = 2 * DIM_W;

    // Settings and image size handed from the register block to the decoder.
    typedef struct packed {
        pixel_mode_t          pixel_mode;
        logic                 rle_enable;
        logic                 load_total;   // width or height written this cycle
        logic [TOTAL_W-1:0]   new_total;    // product after that write
        logic [TOTAL_W-1:0]   total;        // stored product, used on re-arm
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] pixel_value;
        logic [7:0]  repeat_count;
        err_code_t   error_code;
        logic        image_done;
    } result_t;

endpackage

// ===== design/tga_rle_cfg.sv =====
// ----------------------------------------------------------------------------
// TGA RLE configuration registers
// Holds pixel mode, RLE enable and the image size, and keeps the pixel count
// of the image as a registered product.
// ----------------------------------------------------------------------------
module tga_rle_cfg
    import tga_rle_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [DIM_W-1:0] cfg_data,
    output cfg_t             cfg
);

    pixel_mode_t        pixel_mode_reg, pixel_mode_next;
    logic               rle_enable_reg, rle_enable_next;
    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               load_total;
    logic [TOTAL_W-1:0] product;

    always_comb
    begin
        pixel_mode_next = pixel_mode_reg;
        rle_enable_next = rle_enable_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        load_total      = 1'b0;
        if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PIXEL_MODE:   pixel_mode_next = pixel_mode_t'(cfg_data[1:0]);
                CFG_RLE_ENABLE:   rle_enable_next = cfg_data[0];
                CFG_IMAGE_WIDTH:
                begin
                    width_next = cfg_data;
                    load_total = 1'b1;
                end
                CFG_IMAGE_HEIGHT:
                begin
                    height_next = cfg_data;
                    load_total  = 1'b1;
                end
            endcase
        end
        product    = TOTAL_W'(width_next) * TOTAL_W'(height_next);
        total_next = load_total ? product : total_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_mode_reg <= MODE_BGRA;
            rle_enable_reg <= 1'b0;
            width_reg      <= '0;
            height_reg     <= '0;
            total_reg      <= '0;
        end
        else
        begin
            pixel_mode_reg <= pixel_mode_next;
            rle_enable_reg <= rle_enable_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            total_reg      <= total_next;
        end
    end

    assign cfg.pixel_mode = pixel_mode_reg;
    assign cfg.rle_enable = rle_enable_reg;
    assign cfg.load_total = load_total;
    assign cfg.new_total  = product;
    assign cfg.total      = total_reg;

endmodule

// ===== design/tga_rle_dec.sv =====
// ----------------------------------------------------------------------------
// TGA RLE decode stage
// Packet parsing, pixel assembly with BGR(A) to RGB(A) swap, pixel counting
// and error detection for one byte per step.
// ----------------------------------------------------------------------------
module tga_rle_dec
    import tga_rle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       step_en,
    input  logic [7:0] data_byte,
    input  logic       end_of_data,
    output result_t    res
);

    logic               expect_header_reg, expect_header_next;
    logic               packet_is_repeat_reg, packet_is_repeat_next;
    logic [7:0]         packet_left_reg, packet_left_next;
    logic [1:0]         byte_in_pixel_reg, byte_in_pixel_next;
    logic [23:0]        assembly_reg, assembly_next;
    logic [TOTAL_W-1:0] image_left_reg, image_left_next;
    logic               error_reg, error_next;

    logic [2:0]         pixel_size;
    logic               pixel_done;
    logic [31:0]        pixel;
    logic [23:0]        assembly_add;
    logic [7:0]         count;

    // Pixel size and the assembled RGB(A) value for the current byte.
    always_comb
    begin
        unique case (cfg.pixel_mode)
            MODE_GRAY:  pixel_size = 3'd1;
            MODE_BGR:   pixel_size = 3'd3;
            MODE_BGRA,
            MODE_OTHER: pixel_size = 3'd4;
        endcase
        pixel_done = ({1'b0, byte_in_pixel_reg} + 3'd1) >= pixel_size;
        unique case (cfg.pixel_mode)
            MODE_GRAY:  pixel = {24'd0, data_byte};
            MODE_BGR:   pixel = {8'd0, assembly_reg[7:0], assembly_reg[15:8], data_byte};
            MODE_BGRA,
            MODE_OTHER: pixel = {data_byte, assembly_reg[7:0], assembly_reg[15:8],
                                 assembly_reg[23:16]};
        endcase
        assembly_add = assembly_reg;
        unique case (byte_in_pixel_reg)
            2'd0: assembly_add[7:0]   = data_byte;
            2'd1: assembly_add[15:8]  = data_byte;
            2'd2: assembly_add[23:16] = data_byte;
            2'd3: assembly_add        = assembly_reg;
        endcase
        count = {1'b0, data_byte[HDR_COUNT_W-1:0]} + 8'd1;
    end

    always_comb
    begin
        expect_header_next    = expect_header_reg;
        packet_is_repeat_next = packet_is_repeat_reg;
        packet_left_next      = packet_left_reg;
        byte_in_pixel_next    = byte_in_pixel_reg;
        assembly_next         = assembly_reg;
        image_left_next       = image_left_reg;
        error_next            = error_reg;
        res                   = '0;
        res.error_code        = ERR_NONE;

        if (step_en && !error_reg)
        begin
            if (cfg.rle_enable && expect_header_reg)
            begin
                if (end_of_data)
                begin
                    res.valid      = 1'b1;
                    res.error_code = ERR_EARLY_END;
                    res.image_done = 1'b1;
                end
                else if ({{(TOTAL_W-8){1'b0}}, count} > image_left_reg)
                begin
                    res.valid      = 1'b1;
                    res.error_code = ERR_OVERRUN;
                    res.image_done = 1'b1;
                    error_next     = 1'b1;
                end
                else
                begin
                    packet_is_repeat_next = data_byte[HDR_REPEAT_BIT];
                    packet_left_next      = count;
                    image_left_next       = image_left_reg - {{(TOTAL_W-8){1'b0}}, count};
                    expect_header_next    = 1'b0;
                    byte_in_pixel_next    = 2'd0;
                    assembly_next         = '0;
                end
            end
            else if (!cfg.rle_enable && image_left_reg == '0)
            begin
                // Surplus raw bytes are dropped; the last one reports a status.
                if (end_of_data)
                begin
                    res.valid      = 1'b1;
                    res.image_done = 1'b1;
                end
            end
            else if (pixel_done)
            begin
                byte_in_pixel_next = 2'd0;
                assembly_next      = '0;
                res.valid          = 1'b1;
                if (cfg.rle_enable)
                begin
                    if (packet_is_repeat_reg || packet_left_reg <= 8'd1)
                    begin
                        res.repeat_count   = packet_is_repeat_reg ? packet_left_reg : 8'd1;
                        packet_left_next   = 8'd0;
                        expect_header_next = 1'b1;
                    end
                    else
                    begin
                        res.repeat_count = 8'd1;
                        packet_left_next = packet_left_reg - 8'd1;
                    end
                    if (end_of_data && !expect_header_next)
                    begin
                        res.repeat_count = 8'd0;
                        res.error_code   = ERR_EARLY_END;
                    end
                    else
                    begin
                        res.pixel_value = pixel;
                    end
                end
                else
                begin
                    image_left_next = image_left_reg - TOTAL_W'(1);
                    if (end_of_data && image_left_next != '0)
                    begin
                        res.error_code = ERR_EARLY_END;
                    end
                    else
                    begin
                        res.pixel_value  = pixel;
                        res.repeat_count = 8'd1;
                    end
                end
                res.image_done = end_of_data;
            end
            else
            begin
                byte_in_pixel_next = byte_in_pixel_reg + 2'd1;
                assembly_next      = assembly_add;
                if (end_of_data)
                begin
                    res.valid      = 1'b1;
                    res.error_code = ERR_EARLY_END;
                    res.image_done = 1'b1;
                end
            end
        end

        // The last byte of an image re-arms for the next one.
        if (step_en && end_of_data)
        begin
            expect_header_next    = 1'b1;
            packet_is_repeat_next = 1'b0;
            packet_left_next      = 8'd0;
            byte_in_pixel_next    = 2'd0;
            assembly_next         = '0;
            error_next            = 1'b0;
            image_left_next       = cfg.total;
        end
        if (cfg.load_total)
        begin
            image_left_next = cfg.new_total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_header_reg    <= 1'b1;
            packet_is_repeat_reg <= 1'b0;
            packet_left_reg      <= '0;
            byte_in_pixel_reg    <= '0;
            assembly_reg         <= '0;
            image_left_reg       <= '0;
            error_reg            <= 1'b0;
        end
        else
        begin
            expect_header_reg    <= expect_header_next;
            packet_is_repeat_reg <= packet_is_repeat_next;
            packet_left_reg      <= packet_left_next;
            byte_in_pixel_reg    <= byte_in_pixel_next;
            assembly_reg         <= assembly_next;
            image_left_reg       <= image_left_next;
            error_reg            <= error_next;
        end
    end

endmodule

// ===== design/tga_rle_pixel_decoder_core.sv =====
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder core
// Decodes the pixel-data bytes of a TGA image into RGB(A) pixels with repeat
// counts, reporting early ends and packet overruns.
//
// Channel   Dir  Beat contents
// s_axis    in   tdata[7:0] data_byte, tlast end_of_data
// m_axis    out  tdata[31:0] pixel_value, tdata[39:32] repeat_count,
//                tuser[1:0] error_code, tlast image_done
// cfg       in   cfg_index selects the register, cfg_data[15:0] the value
//
// One byte is accepted every cycle while m_axis does not stall; a result
// reaches m_axis after its byte has passed through the input register and the
// result register. The decode stage between them works on one byte per step.
// Reset clears all decode state and restores pixel mode BGRA, raw data and
// an image size of zero. A stall on m_axis holds the result register and
// then the input register; s_tready falls only when both are full.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_core
    import tga_rle_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,    // [7:0] data_byte
    input  logic             s_tlast,    // end_of_data
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [39:0]      m_tdata,    // [31:0] pixel_value, [39:32] repeat_count
    output logic [1:0]       m_tuser,    // [1:0] error_code
    output logic             m_tlast,    // image_done
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [DIM_W-1:0] cfg_data
);

    cfg_t        cfg;
    result_t     res;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_valid_reg, out_valid_next;
    logic [39:0] out_data_reg;
    err_code_t   out_err_reg;
    logic        out_done_reg;
    logic        s_take;
    logic        advance;

    tga_rle_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tga_rle_dec u_dec (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .step_en     (advance),
        .data_byte   (in_byte_reg),
        .end_of_data (in_last_reg),
        .res         (res)
    );

    // The held byte moves on whenever the result register is free or drains.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = res.valid;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && res.valid)
        begin
            out_data_reg <= {res.repeat_count, res.pixel_value};
            out_err_reg  <= res.error_code;
            out_done_reg <= res.image_done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;
    assign m_tlast  = out_done_reg;

    // Every error beat closes the image and carries no pixel.
    a_error_closes_image: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ERR_EARLY_END || m_tuser == ERR_OVERRUN) |-> m_tlast)
        else $error("error beat without image_done");

    a_error_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ERR_NONE |-> m_tdata == 40'd0)
        else $error("error beat carries pixel data");

    // A held byte that cannot advance must stay in the input register.
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg)
                                     && $stable(in_last_reg))
        else $error("input register lost a stalled byte");

    // A pixel beat always has a repeat count between 1 and 128.
    a_repeat_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ERR_NONE && m_tdata[39:32] != 8'd0
        |-> m_tdata[39:32] <= 8'd128)
        else $error("repeat count out of range");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder core testbench
// Streams pixel-data bytes through the decoder under random settings and
// random handshake gaps. A scoreboard decodes every accepted byte itself and
// checks each result beat against its own decoding, field by field.
// ----------------------------------------------------------------------------
module tb
    import tga_rle_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned RANDOM_BYTES = 1200;
    localparam int unsigned HOLD_CYCLES  = 300;

    typedef struct {
        logic [31:0] pixel;
        logic [7:0]  run_len;
        err_code_t   err;
        logic        done;
    } pixel_result_t;

    class pixel_scoreboard;
        pixel_mode_t   mode;
        logic          rle_on;
        logic [15:0]   width;
        logic [15:0]   height;
        logic          want_header;
        logic          run_is_repeat;
        logic [7:0]    run_left;
        logic [1:0]    byte_idx;
        logic [23:0]   partial;
        logic [31:0]   pixels_left;
        logic          err_hold;
        pixel_result_t expected_pixels[$];
        int unsigned   mismatches;

        function new();
            mode       = MODE_BGRA;
            rle_on     = 1'b0;
            width      = '0;
            height     = '0;
            mismatches = 0;
            rearm();
        endfunction

        function void rearm();
            want_header   = 1'b1;
            run_is_repeat = 1'b0;
            run_left      = '0;
            byte_idx      = '0;
            partial       = '0;
            err_hold      = 1'b0;
            pixels_left   = 32'(width) * 32'(height);
        endfunction

        function int unsigned pixel_size();
            case (mode)
                MODE_GRAY: return 1;
                MODE_BGR:  return 3;
                default:   return 4;
            endcase
        endfunction

        function int unsigned pending();
            return expected_pixels.size();
        endfunction

        function void write_reg(cfg_index_t idx, logic [15:0] value);
            case (idx)
                CFG_PIXEL_MODE: mode = pixel_mode_t'(value[1:0]);
                CFG_RLE_ENABLE: rle_on = value[0];
                CFG_IMAGE_WIDTH:
                begin
                    width       = value;
                    pixels_left = 32'(width) * 32'(height);
                end
                default:
                begin
                    height      = value;
                    pixels_left = 32'(width) * 32'(height);
                end
            endcase
        endfunction

        function void push_result(logic [31:0] pix, logic [7:0] run, err_code_t err,
                                  logic done);
            pixel_result_t r;
            r.pixel   = pix;
            r.run_len = run;
            r.err     = err;
            r.done    = done;
            expected_pixels.push_back(r);
        endfunction

        // Adds one byte to the pixel being assembled; returns 1 with the
        // RGB(A) value once the pixel is complete for the current mode.
        function bit take_byte(logic [7:0] b, output logic [31:0] pix);
            int unsigned size;
            size = pixel_size();
            pix  = '0;
            if (int'(byte_idx) + 1 >= int'(size))
            begin
                case (size)
                    1:       pix = {24'h0, b};
                    3:       pix = {8'h0, partial[7:0], partial[15:8], b};
                    default: pix = {b, partial[7:0], partial[15:8], partial[23:16]};
                endcase
                byte_idx = '0;
                partial  = '0;
                return 1'b1;
            end
            case (byte_idx)
                2'd0:    partial[7:0]   = b;
                2'd1:    partial[15:8]  = b;
                default: partial[23:16] = b;
            endcase
            byte_idx = byte_idx + 2'd1;
            return 1'b0;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            logic [31:0] pix;
            logic [7:0]  cnt;
            logic [7:0]  run;
            if (err_hold)
            begin
                if (last)
                    rearm();
                return;
            end
            if (rle_on)
            begin
                if (want_header)
                begin
                    cnt = {1'b0, b[6:0]} + 8'd1;
                    if (last)
                        push_result('0, '0, ERR_EARLY_END, 1'b1);
                    else if (32'(cnt) > pixels_left)
                    begin
                        push_result('0, '0, ERR_OVERRUN, 1'b1);
                        err_hold = 1'b1;
                        return;
                    end
                    else
                    begin
                        run_is_repeat = b[HDR_REPEAT_BIT];
                        run_left      = cnt;
                        pixels_left   = pixels_left - 32'(cnt);
                        want_header   = 1'b0;
                        byte_idx      = '0;
                        partial       = '0;
                    end
                end
                else if (take_byte(b, pix))
                begin
                    if (run_is_repeat || run_left <= 8'd1)
                    begin
                        run         = run_is_repeat ? run_left : 8'd1;
                        run_left    = '0;
                        want_header = 1'b1;
                    end
                    else
                    begin
                        run      = 8'd1;
                        run_left = run_left - 8'd1;
                    end
                    // Ending in the middle of a literal packet is an early end.
                    if (last && !want_header)
                        push_result('0, '0, ERR_EARLY_END, 1'b1);
                    else
                        push_result(pix, run, ERR_NONE, last);
                end
                else if (last)
                    push_result('0, '0, ERR_EARLY_END, 1'b1);
            end
            else
            begin
                if (pixels_left == 0)
                begin
                    if (last)
                        push_result('0, '0, ERR_NONE, 1'b1);
                end
                else if (take_byte(b, pix))
                begin
                    pixels_left = pixels_left - 32'd1;
                    if (last && pixels_left != 0)
                        push_result('0, '0, ERR_EARLY_END, 1'b1);
                    else
                        push_result(pix, 8'd1, ERR_NONE, last);
                end
                else if (last)
                    push_result('0, '0, ERR_EARLY_END, 1'b1);
            end
            if (last)
                rearm();
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 50)
                $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(logic [31:0] pix, logic [7:0] run, logic [1:0] err,
                          logic done);
            pixel_result_t want;
            if (expected_pixels.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat pixel=%h run=%0d err=%0d done=%b",
                                          pix, run, err, done));
                return;
            end
            want = expected_pixels.pop_front();
            if (pix !== want.pixel)
                report_mismatch($sformatf("pixel_value %h, expected %h", pix, want.pixel));
            if (run !== want.run_len)
                report_mismatch($sformatf("repeat_count %0d, expected %0d", run, want.run_len));
            if (err !== want.err)
                report_mismatch($sformatf("error_code %0d, expected %s", err, want.err.name()));
            if (done !== want.done)
                report_mismatch($sformatf("image_done %b, expected %b", done, want.done));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;     // [7:0] data_byte
    logic              s_tlast;     // end_of_data
    logic              m_tvalid;
    logic              m_tready;
    logic [39:0]       m_tdata;     // [31:0] pixel_value, [39:32] repeat_count
    logic [1:0]        m_tuser;     // [1:0] error_code
    logic              m_tlast;     // image_done
    logic              cfg_wr_en;
    logic [1:0]        cfg_index;
    logic [DIM_W-1:0]  cfg_data;

    pixel_scoreboard   sb;
    logic [7:0]        image_bytes[$];
    bit                calm;
    bit                hold_off_req;
    int unsigned       cycle_count;

    tga_rle_pixel_decoder_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Result side: random ready stretches and stalls, plus one long hold-off
    // that backs the decoder up until it stalls its input.
    initial
    begin
        int unsigned gap;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
                gap = pick_gap();
                if (gap != 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[31:0], m_tdata[39:32], m_tuser, m_tlast);
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = calm ? 0 : pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_byte(b, last);
    endtask

    task automatic send_image();
        for (int i = 0; i < image_bytes.size(); i++)
            send_byte(image_bytes[i], i == image_bytes.size() - 1);
    endtask

    // A byte that gives no result may still be in the pipeline when the last
    // result arrives, so wait on until it has left the input and result registers.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_settings(input pixel_mode_t m, input logic rle,
                                  input logic [15:0] w, input logic [15:0] h);
        logic [15:0] values[4];
        cfg_index_t  idx;
        values[0] = 16'(m);
        values[1] = 16'(rle);
        values[2] = w;
        values[3] = h;
        for (int i = 0; i < 4; i++)
        begin
            idx = cfg_index_t'(i);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= values[i];
            @(posedge clk);
            sb.write_reg(idx, values[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Builds the byte stream of one image for the current settings: mostly
    // well-formed, sometimes cut short, padded or plain noise.
    task automatic build_stream(input int unsigned total_px);
        int unsigned size;
        int unsigned left;
        int unsigned c;
        int unsigned cmax;
        int unsigned r;
        int unsigned drop;
        logic        rep_pkt;
        image_bytes.delete();
        size = sb.pixel_size();
        left = (total_px > 300) ? $urandom_range(1, 40) : total_px;
        if (sb.rle_on)
        begin
            while (left != 0)
            begin
                cmax = (left > 128) ? 128 : left;
                r    = $urandom_range(0, 99);
                if (r < 25)
                    c = 1;
                else if (r < 45)
                    c = cmax;
                else
                    c = $urandom_range(1, cmax);
                rep_pkt = $urandom_range(0, 1);
                // Long literal packets are costly, so most long runs repeat.
                if (!rep_pkt && c > 24 && $urandom_range(0, 3) != 0)
                    rep_pkt = 1'b1;
                image_bytes.push_back({rep_pkt, 7'(c - 1)});
                repeat (rep_pkt ? size : c * size)
                    image_bytes.push_back(8'($urandom_range(0, 255)));
                left -= c;
            end
        end
        else
        begin
            repeat (left * size)
                image_bytes.push_back(8'($urandom_range(0, 255)));
        end
        r = $urandom_range(0, 99);
        if (image_bytes.size() == 0 || r >= 95)
        begin
            image_bytes.delete();
            repeat ($urandom_range(1, 12))
                image_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (r >= 88)
        begin
            repeat ($urandom_range(1, 8))
                image_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (r >= 80 && image_bytes.size() > 1)
        begin
            drop = (image_bytes.size() - 1 > 6) ? 6 : image_bytes.size() - 1;
            repeat ($urandom_range(1, drop))
                void'(image_bytes.pop_back());
        end
    endtask

    initial
    begin
        int unsigned random_sent;
        int unsigned r;
        logic [15:0] w;
        logic [15:0] h;
        sb           = new();
        calm         = 1'b0;
        hold_off_req = 1'b0;
        random_sent  = 0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_PIXEL_MODE;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: BGRA, raw, empty image, so the byte is surplus.
        image_bytes = '{8'hFF};
        send_image();

        // Largest image in gray raw, ended long before it is full.
        wait_idle();
        apply_settings(MODE_GRAY, 1'b0, 16'hFFFF, 16'hFFFF);
        image_bytes = '{8'h00, 8'hFF};
        send_image();

        // One repeat packet covering a whole BGR image.
        wait_idle();
        apply_settings(MODE_BGR, 1'b1, 16'd1, 16'd2);
        image_bytes = '{8'h81, 8'h11, 8'h22, 8'h33};
        send_image();

        // A 128-pixel header overruns the image; the rest is ignored.
        image_bytes = '{8'hFF, 8'h55, 8'hAA};
        send_image();

        // Stream ends on a header byte.
        image_bytes = '{8'h00};
        send_image();

        // Mode three, literal packet left unfinished.
        wait_idle();
        apply_settings(MODE_OTHER, 1'b1, 16'd2, 16'd1);
        image_bytes = '{8'h01, 8'h10, 8'h20, 8'h30, 8'h40};
        send_image();

        // Ending on a packet boundary with pixels missing is fine.
        wait_idle();
        apply_settings(MODE_GRAY, 1'b1, 16'd4, 16'd1);
        image_bytes = '{8'h80, 8'h7E};
        send_image();

        // Pixel mode changed with half a pixel assembled.
        wait_idle();
        apply_settings(MODE_BGRA, 1'b0, 16'd1, 16'd1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        wait_idle();
        apply_settings(MODE_GRAY, 1'b0, 16'd1, 16'd1);
        send_byte(8'hC3, 1'b1);

        // Raw stream ends inside a pixel.
        wait_idle();
        apply_settings(MODE_BGR, 1'b0, 16'd2, 16'd2);
        image_bytes = '{8'h01};
        send_image();

        // A long gray stream keeps coming while the receiver holds off, so
        // both registers fill and the input stalls.
        wait_idle();
        apply_settings(MODE_GRAY, 1'b0, 16'd96, 16'd1);
        hold_off_req = 1'b1;
        calm         = 1'b1;
        image_bytes.delete();
        repeat (96)
            image_bytes.push_back(8'($urandom_range(0, 255)));
        send_image();
        calm = 1'b0;

        while (random_sent < RANDOM_BYTES)
        begin
            if (random_sent == 0 || $urandom_range(0, 99) < 40)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                begin
                    w = '0;
                    h = 16'($urandom_range(0, 3));
                end
                else if (r < 8)
                begin
                    w = 16'($urandom_range(1, 5));
                    h = '0;
                end
                else if (r < 88)
                begin
                    w = 16'($urandom_range(1, 6));
                    h = 16'($urandom_range(1, 6));
                end
                else if (r < 96)
                begin
                    w = 16'($urandom_range(20, 64));
                    h = 16'($urandom_range(2, 4));
                end
                else
                begin
                    w = 16'($urandom_range(1000, 65535));
                    h = (r < 98) ? 16'hFFFF : 16'($urandom_range(1, 65535));
                end
                wait_idle();
                apply_settings(pixel_mode_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                               w, h);
            end
            calm = ($urandom_range(0, 3) == 0);
            build_stream(32'(sb.width) * 32'(sb.height));
            send_image();
            random_sent += image_bytes.size();
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
